>>> hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define STQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/stq_pkg.sv
// types and constants of the sorted timer queue
package stq_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    K_ADD  = 2'd0,
    K_ADJ  = 2'd1,
    K_DEL  = 2'd2,
    K_TICK = 2'd3
  } stq_kind_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_W,
    ST_ADD_CMP,
    ST_ADJ_RD,
    ST_ADJ_NX,
    ST_ADJ_CMP,
    ST_DEL_RD,
    ST_UL_LD,
    ST_UL_P,
    ST_UL_N,
    ST_WALK_HEAD,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_LNK_S,
    ST_LNK_P,
    ST_LNK_C,
    ST_TK_RD,
    ST_TK_CMP,
    ST_TK_FIN
  } stq_state_t;

  typedef struct packed {
    logic exp;
    logic tag;
    logic nxt;
    logic prv;
  } stq_we_t;

endpackage

>>> hdl/stq_mem.sv
// entry storage: expiry and tag memory plus link memory, registered read
module stq_mem
  import stq_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                             clk,
  input  stq_we_t                          we,
  input  logic [$clog2(SLOTS)-1:0]         waddr,
  input  logic [31:0]                      wexp,
  input  logic [31:0]                      wtag,
  input  logic [$clog2(SLOTS+1)-1:0]       wnxt,
  input  logic [$clog2(SLOTS+1)-1:0]       wprv,
  input  logic [$clog2(SLOTS)-1:0]         raddr,
  output logic [31:0]                      rexp,
  output logic [31:0]                      rtag,
  output logic [$clog2(SLOTS+1)-1:0]       rnxt,
  output logic [$clog2(SLOTS+1)-1:0]       rprv
);

  localparam int LW = $clog2(SLOTS + 1);

  logic [63:0]     data_mem [SLOTS];
  logic [2*LW-1:0] link_mem [SLOTS];
  logic [63:0]     data_r;
  logic [2*LW-1:0] link_r;

  always_ff @(posedge clk) begin
    if (we.exp) data_mem[waddr][63:32] <= wexp;
    if (we.tag) data_mem[waddr][31:0] <= wtag;
    if (we.nxt) link_mem[waddr][2*LW-1:LW] <= wnxt;
    if (we.prv) link_mem[waddr][LW-1:0] <= wprv;
    data_r <= data_mem[raddr];
    link_r <= link_mem[raddr];
  end

  assign rexp = data_r[63:32];
  assign rtag = data_r[31:0];
  assign rnxt = link_r[2*LW-1:LW];
  assign rprv = link_r[LW-1:0];

endmodule

>>> hdl/sorted_timer_queue.sv
// sorted timer queue top level: command sequencer, list head and tail, result register
// Timers live in a doubly linked list kept in a one-port-read memory, sorted by
// expiry, equal keys in arrival order, but an adjust checks only the next entry
// and so never moves a lowered expiry forward. One transaction is worked at a time
// and in_stall stays high until it is done. Add writes the entry, walks the list
// from the head in order and links the entry in; delete unlinks the entry from its
// neighbours; an adjust rewrites the expiry, stays in place unless the next entry
// expires no later, and else is unlinked and walked in again from the head. Tick
// pops expired timers from the head (at most 16 per tick); results leave through
// an output register, and a tick waits there while the consumer stalls.
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_expiry,
  input  logic [31:0] in_tag,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_expired_slot,
  output logic [31:0] out_expired_tag,
  output logic        out_last
);

`include "assert_macros.svh"

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  stq_state_t state_r, state_nxt;
  logic [LW-1:0] s_r, s_nxt, p_r, p_nxt, c_r, c_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [31:0] e_r, e_nxt, t_r, t_nxt, now_r, now_nxt;
  logic is_adj_r, is_adj_nxt;
  logic [SLOTS-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic pend_v_r, pend_v_nxt;
  logic [3:0] pend_slot_r, pend_slot_nxt;
  logic [31:0] pend_tag_r, pend_tag_nxt;
  logic out_v_r, out_v_nxt, out_last_r, out_last_nxt;
  logic [3:0] out_slot_r, out_slot_nxt;
  logic [31:0] out_tag_r, out_tag_nxt;

  stq_we_t we;
  logic [LW-1:0] wa, ra, wnxt, wprv, in_slot_lw;
  logic [31:0] rexp, rtag;
  logic [LW-1:0] rnxt, rprv;
  logic push, push_last, out_free, in_rng;

  stq_mem #(.SLOTS(SLOTS)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (wa[SW-1:0]),
    .wexp  (e_r),
    .wtag  (t_r),
    .wnxt  (wnxt),
    .wprv  (wprv),
    .raddr (ra[SW-1:0]),
    .rexp  (rexp),
    .rtag  (rtag),
    .rnxt  (rnxt),
    .rprv  (rprv)
  );

  assign in_slot_lw = LW'(in_slot);
  assign in_rng = (7'(in_slot) < 7'(SLOTS));
  assign out_free = !out_v_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !rst_n;

  always_comb begin
    state_nxt = state_r;
    s_nxt = s_r;
    e_nxt = e_r;
    t_nxt = t_r;
    now_nxt = now_r;
    is_adj_nxt = is_adj_r;
    p_nxt = p_r;
    c_nxt = c_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt = occ_r;
    cnt_nxt = cnt_r;
    pend_v_nxt = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_tag_nxt = pend_tag_r;
    we = '0;
    wa = s_r;
    ra = s_r;
    wnxt = c_r;
    wprv = p_r;
    push = 1'b0;
    push_last = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          s_nxt = in_slot_lw;
          e_nxt = in_expiry;
          t_nxt = in_tag;
          now_nxt = in_now;
          cnt_nxt = '0;
          is_adj_nxt = (stq_kind_t'(in_kind) == K_ADJ);
          unique case (stq_kind_t'(in_kind))
            K_TICK: state_nxt = ST_TK_RD;
            K_ADD: if (in_rng && !occ_r[in_slot_lw[SW-1:0]]) state_nxt = ST_ADD_W;
            K_ADJ: if (in_rng && occ_r[in_slot_lw[SW-1:0]]) state_nxt = ST_ADJ_RD;
            K_DEL: if (in_rng && occ_r[in_slot_lw[SW-1:0]]) state_nxt = ST_DEL_RD;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_W: begin
        we.exp = 1'b1;
        we.tag = 1'b1;
        occ_nxt[s_r[SW-1:0]] = 1'b1;
        if (head_r == NIL) begin
          p_nxt = NIL;
          c_nxt = NIL;
          state_nxt = ST_LNK_S;
        end else begin
          ra = head_r;
          state_nxt = ST_ADD_CMP;
        end
      end
      ST_ADD_CMP: begin
        if (e_r < rexp) begin
          p_nxt = NIL;
          c_nxt = head_r;
          state_nxt = ST_LNK_S;
        end else begin
          p_nxt = head_r;
          c_nxt = rnxt;
          state_nxt = ST_WALK_RD;
        end
      end
      ST_ADJ_RD: begin
        we.exp = 1'b1;
        state_nxt = ST_ADJ_NX;
      end
      ST_ADJ_NX: begin
        p_nxt = rprv;
        c_nxt = rnxt;
        if (rnxt == NIL) begin
          state_nxt = ST_IDLE;
        end else begin
          ra = rnxt;
          state_nxt = ST_ADJ_CMP;
        end
      end
      ST_ADJ_CMP: begin
        state_nxt = (e_r < rexp) ? ST_IDLE : ST_UL_P;
      end
      ST_DEL_RD: begin
        state_nxt = ST_UL_LD;
      end
      ST_UL_LD: begin
        p_nxt = rprv;
        c_nxt = rnxt;
        state_nxt = ST_UL_P;
      end
      ST_UL_P: begin
        if (p_r == NIL) begin
          head_nxt = c_r;
        end else begin
          we.nxt = 1'b1;
          wa = p_r;
          wnxt = c_r;
        end
        state_nxt = ST_UL_N;
      end
      ST_UL_N: begin
        if (c_r == NIL) begin
          tail_nxt = p_r;
        end else begin
          we.prv = 1'b1;
          wa = c_r;
          wprv = p_r;
        end
        if (!is_adj_r) begin
          occ_nxt[s_r[SW-1:0]] = 1'b0;
          state_nxt = ST_IDLE;
        end else if (head_r == NIL) begin
          p_nxt = NIL;
          c_nxt = NIL;
          state_nxt = ST_LNK_S;
        end else begin
          ra = head_r;
          state_nxt = ST_WALK_HEAD;
        end
      end
      ST_WALK_HEAD: begin
        p_nxt = head_r;
        c_nxt = rnxt;
        state_nxt = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        if (c_r == NIL) begin
          state_nxt = ST_LNK_S;
        end else begin
          ra = c_r;
          state_nxt = ST_WALK_CMP;
        end
      end
      ST_WALK_CMP: begin
        if (rexp > e_r) begin
          state_nxt = ST_LNK_S;
        end else begin
          p_nxt = c_r;
          c_nxt = rnxt;
          state_nxt = ST_WALK_RD;
        end
      end
      ST_LNK_S: begin
        we.nxt = 1'b1;
        we.prv = 1'b1;
        state_nxt = ST_LNK_P;
      end
      ST_LNK_P: begin
        if (p_r == NIL) begin
          head_nxt = s_r;
        end else begin
          we.nxt = 1'b1;
          wa = p_r;
          wnxt = s_r;
        end
        state_nxt = ST_LNK_C;
      end
      ST_LNK_C: begin
        if (c_r == NIL) begin
          tail_nxt = s_r;
        end else begin
          we.prv = 1'b1;
          wa = c_r;
          wprv = s_r;
        end
        state_nxt = ST_IDLE;
      end
      ST_TK_RD: begin
        if (head_r == NIL || cnt_r == CNT_W'(MAX_RESULTS)) begin
          state_nxt = ST_TK_FIN;
        end else begin
          ra = head_r;
          state_nxt = ST_TK_CMP;
        end
      end
      ST_TK_CMP: begin
        ra = head_r;
        if (now_r >= rexp) begin
          if (!pend_v_r || out_free) begin
            push = pend_v_r;
            pend_v_nxt = 1'b1;
            pend_slot_nxt = 4'(head_r);
            pend_tag_nxt = rtag;
            occ_nxt[head_r[SW-1:0]] = 1'b0;
            head_nxt = rnxt;
            if (rnxt == NIL) begin
              tail_nxt = NIL;
            end else begin
              we.prv = 1'b1;
              wa = rnxt;
              wprv = NIL;
            end
            cnt_nxt = cnt_r + 1'b1;
            state_nxt = ST_TK_RD;
          end
        end else begin
          state_nxt = ST_TK_FIN;
        end
      end
      ST_TK_FIN: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          push = 1'b1;
          push_last = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_slot_nxt = out_slot_r;
    out_tag_nxt = out_tag_r;
    out_last_nxt = out_last_r;
    if (push) begin
      out_v_nxt = 1'b1;
      out_slot_nxt = pend_slot_r;
      out_tag_nxt = pend_tag_r;
      out_last_nxt = push_last;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r <= NIL;
      tail_r <= NIL;
      occ_r <= '0;
      cnt_r <= '0;
      pend_v_r <= 1'b0;
      out_v_r <= 1'b0;
      is_adj_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r <= occ_nxt;
      cnt_r <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r <= out_v_nxt;
      is_adj_r <= is_adj_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    e_r <= e_nxt;
    t_r <= t_nxt;
    now_r <= now_nxt;
    p_r <= p_nxt;
    c_r <= c_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_tag_r <= pend_tag_nxt;
    out_slot_r <= out_slot_nxt;
    out_tag_r <= out_tag_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_v_r;
  assign out_expired_slot = out_slot_r;
  assign out_expired_tag = out_tag_r;
  assign out_last = out_last_r;

  `STQ_ASSERT_IMPL(a_head_tail_nil, (state_r == ST_IDLE), ((head_r == NIL) == (tail_r == NIL)), "head and tail disagree on empty list")
  `STQ_ASSERT_IMPL(a_empty_no_head, (state_r == ST_IDLE && occ_r == '0), (head_r == NIL), "list head set while no slot is occupied")
  `STQ_ASSERT_IMPL(a_tick_bound, 1'b1, (cnt_r <= CNT_W'(MAX_RESULTS)), "tick popped too many timers")
  `STQ_ASSERT_NEXT(a_last_ends_tick, (state_r == ST_TK_FIN && pend_v_r && out_free), (out_valid && out_last && state_r == ST_IDLE), "final expiry not marked last")

endmodule
